FILE: src/branch_distance_unit_top_assert.svh
// Assertion macros shared by the branch-distance unit checkers.
`ifndef BRANCH_DISTANCE_UNIT_TOP_ASSERT_SVH
`define BRANCH_DISTANCE_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define BDU_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("branch distance unit: assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define BDU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("branch distance unit: assertion failed");

`endif

FILE: src/bdu_pkg.sv
// Shared constants and types of the branch-distance unit.
`default_nettype none

package bdu_pkg;

	// Default operand and distance widths.
	localparam int unsigned OPERAND_WIDTH_DEF  = 32;
	localparam int unsigned DISTANCE_WIDTH_DEF = 48;

	// Offset register.
	localparam int unsigned K_WIDTH = 8;
	localparam logic [K_WIDTH-1:0] K_RESET = 8'd1;

	// Function codes.
	localparam int unsigned FUNC_WIDTH = 4;

	typedef enum logic [FUNC_WIDTH-1:0] {
		FUNC_GT  = 4'd0,
		FUNC_GE  = 4'd1,
		FUNC_LT  = 4'd2,
		FUNC_LE  = 4'd3,
		FUNC_EQ  = 4'd4,
		FUNC_NE  = 4'd5,
		FUNC_AND = 4'd6,
		FUNC_OR  = 4'd7,
		FUNC_NOT = 4'd8
	} func_t;

endpackage

`default_nettype wire

FILE: src/branch_distance_unit_top.sv
// Branch-distance unit: comparisons and logical combines with saturating distances.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready   | func, operands, lhs and rhs sub-results
//   out     | output    | out_valid / out_ready | outcome, true_distance, false_distance
//   cfg     | input     | cfg_valid / cfg_ready | k_offset
//
// One beat per cycle on each channel while the output is not stalled; an input beat passes
// the input register and then the result register around the single evaluation stage.
// The evaluation path is one operand subtract, one add of the offset and a saturation compare.
// Reset clears the valid bits and sets the offset to one; cfg_ready is always high.
// A stalled output holds its beat; the input register keeps taking beats while the
// result register is free or being emptied.
`default_nettype none

module branch_distance_unit_top #(
	parameter int unsigned OPERAND_WIDTH  = bdu_pkg::OPERAND_WIDTH_DEF,
	parameter int unsigned DISTANCE_WIDTH = bdu_pkg::DISTANCE_WIDTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// Configuration channel.
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire        [bdu_pkg::K_WIDTH-1:0]      k_offset,
	// Input channel.
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire        [bdu_pkg::FUNC_WIDTH-1:0]   func,
	input  wire signed [OPERAND_WIDTH-1:0]         left_operand,
	input  wire signed [OPERAND_WIDTH-1:0]         right_operand,
	input  wire                                    lhs_outcome,
	input  wire        [DISTANCE_WIDTH-1:0]        lhs_true_dist,
	input  wire        [DISTANCE_WIDTH-1:0]        lhs_false_dist,
	input  wire                                    rhs_outcome,
	input  wire        [DISTANCE_WIDTH-1:0]        rhs_true_dist,
	input  wire        [DISTANCE_WIDTH-1:0]        rhs_false_dist,
	// Output channel.
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic                                   outcome,
	output logic       [DISTANCE_WIDTH-1:0]        true_distance,
	output logic       [DISTANCE_WIDTH-1:0]        false_distance
);

	localparam int unsigned SUM_W =
		((OPERAND_WIDTH > DISTANCE_WIDTH) ? OPERAND_WIDTH : DISTANCE_WIDTH) + 1;
	localparam logic [DISTANCE_WIDTH-1:0] DIST_MAX = {DISTANCE_WIDTH{1'b1}};

	// Offset register.
	logic [bdu_pkg::K_WIDTH-1:0] k_q;

	// Input register.
	logic                              valid_s1;
	logic [bdu_pkg::FUNC_WIDTH-1:0]    func_s1;
	logic signed [OPERAND_WIDTH-1:0]   left_s1;
	logic signed [OPERAND_WIDTH-1:0]   right_s1;
	logic                              lhs_out_s1;
	logic [DISTANCE_WIDTH-1:0]         lhs_td_s1;
	logic [DISTANCE_WIDTH-1:0]         lhs_fd_s1;
	logic                              rhs_out_s1;
	logic [DISTANCE_WIDTH-1:0]         rhs_td_s1;
	logic [DISTANCE_WIDTH-1:0]         rhs_fd_s1;

	// Result register.
	logic                              valid_s2;
	logic                              outcome_s2;
	logic [DISTANCE_WIDTH-1:0]         td_s2;
	logic [DISTANCE_WIDTH-1:0]         fd_s2;

	// Evaluation signals.
	logic                              s1_advance;
	logic                              a_gt;
	logic                              a_eq;
	logic                              a_ge;
	logic [OPERAND_WIDTH-1:0]          mag;
	logic [SUM_W-1:0]                  dk_sum;
	logic [DISTANCE_WIDTH-1:0]         dist_k;
	logic [DISTANCE_WIDTH:0]           td_sum;
	logic [DISTANCE_WIDTH:0]           fd_sum;
	logic [DISTANCE_WIDTH-1:0]         td_sat;
	logic [DISTANCE_WIDTH-1:0]         fd_sat;
	logic [DISTANCE_WIDTH-1:0]         td_min;
	logic [DISTANCE_WIDTH-1:0]         fd_min;
	logic                              is_cmp;
	logic                              cmp_res;
	logic                              res_c;
	logic [DISTANCE_WIDTH-1:0]         td_c;
	logic [DISTANCE_WIDTH-1:0]         fd_c;

	// Handshake: the input register moves on whenever the result register can take it.
	assign s1_advance = !valid_s2 || out_ready;
	assign in_ready   = !valid_s1 || s1_advance;
	assign cfg_ready  = 1'b1;

	assign out_valid      = valid_s2;
	assign outcome        = outcome_s2;
	assign true_distance  = td_s2;
	assign false_distance = fd_s2;

	// Offset register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= bdu_pkg::K_RESET;
		end else if (cfg_valid) begin
			k_q <= k_offset;
		end
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1    <= func;
			left_s1    <= left_operand;
			right_s1   <= right_operand;
			lhs_out_s1 <= lhs_outcome;
			lhs_td_s1  <= lhs_true_dist;
			lhs_fd_s1  <= lhs_false_dist;
			rhs_out_s1 <= rhs_outcome;
			rhs_td_s1  <= rhs_true_dist;
			rhs_fd_s1  <= rhs_false_dist;
		end
	end

	// Operand order and the offset distance |a - b| + k, saturated.
	always_comb begin
		a_gt   = left_s1 > right_s1;
		a_eq   = left_s1 == right_s1;
		a_ge   = a_gt || a_eq;
		mag    = a_ge ? OPERAND_WIDTH'(left_s1 - right_s1)
		              : OPERAND_WIDTH'(right_s1 - left_s1);
		dk_sum = SUM_W'(mag) + SUM_W'(k_q);
		dist_k = (dk_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : dk_sum[DISTANCE_WIDTH-1:0];
	end

	// Sums and minimums of the sub-result distances.
	always_comb begin
		td_sum = {1'b0, lhs_td_s1} + {1'b0, rhs_td_s1};
		fd_sum = {1'b0, lhs_fd_s1} + {1'b0, rhs_fd_s1};
		td_sat = td_sum[DISTANCE_WIDTH] ? DIST_MAX : td_sum[DISTANCE_WIDTH-1:0];
		fd_sat = fd_sum[DISTANCE_WIDTH] ? DIST_MAX : fd_sum[DISTANCE_WIDTH-1:0];
		td_min = (lhs_td_s1 < rhs_td_s1) ? lhs_td_s1 : rhs_td_s1;
		fd_min = (lhs_fd_s1 < rhs_fd_s1) ? lhs_fd_s1 : rhs_fd_s1;
	end

	// Function select. Every comparison has zero distance on the side it already meets
	// and the offset distance on the other side.
	always_comb begin
		is_cmp  = 1'b0;
		cmp_res = 1'b0;
		res_c   = 1'b0;
		td_c    = '0;
		fd_c    = '0;
		case (func_s1)
			bdu_pkg::FUNC_GT: begin
				is_cmp  = 1'b1;
				cmp_res = a_gt;
			end
			bdu_pkg::FUNC_GE: begin
				is_cmp  = 1'b1;
				cmp_res = a_ge;
			end
			bdu_pkg::FUNC_LT: begin
				is_cmp  = 1'b1;
				cmp_res = !a_ge;
			end
			bdu_pkg::FUNC_LE: begin
				is_cmp  = 1'b1;
				cmp_res = !a_gt;
			end
			bdu_pkg::FUNC_EQ: begin
				is_cmp  = 1'b1;
				cmp_res = a_eq;
			end
			bdu_pkg::FUNC_NE: begin
				is_cmp  = 1'b1;
				cmp_res = !a_eq;
			end
			bdu_pkg::FUNC_AND: begin
				if (lhs_out_s1 && rhs_out_s1) begin
					res_c = 1'b1;
					fd_c  = fd_min;
				end else begin
					td_c  = td_sat;
				end
			end
			bdu_pkg::FUNC_OR: begin
				if (lhs_out_s1 || rhs_out_s1) begin
					res_c = 1'b1;
					fd_c  = fd_sat;
				end else begin
					td_c  = td_min;
				end
			end
			bdu_pkg::FUNC_NOT: begin
				res_c = !lhs_out_s1;
				td_c  = lhs_fd_s1;
				fd_c  = lhs_td_s1;
			end
			default: begin
				res_c = 1'b0;
			end
		endcase
		if (is_cmp) begin
			res_c = cmp_res;
			td_c  = cmp_res ? '0 : dist_k;
			fd_c  = cmp_res ? dist_k : '0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_advance) begin
			outcome_s2 <= res_c;
			td_s2      <= td_c;
			fd_s2      <= fd_c;
		end
	end

endmodule

`default_nettype wire

FILE: src/bdu_checker.sv
// Port-level checker for the branch-distance unit and its bind.
`default_nettype none

`include "branch_distance_unit_top_assert.svh"

module bdu_checker #(
	parameter int unsigned DISTANCE_WIDTH = bdu_pkg::DISTANCE_WIDTH_DEF
) (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_ready,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire                      outcome,
	input wire [DISTANCE_WIDTH-1:0] true_distance,
	input wire [DISTANCE_WIDTH-1:0] false_distance
);

	// A stalled result beat stays put.
	`BDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(true_distance) && $stable(false_distance))

	// Once an accepted beat has passed the input register and the result register, out_valid is high.
	`BDU_ASSERT_NEXT(a_latency, in_valid && in_ready, ##1 out_valid)

	// With both stages full and the output stalled, no further input is taken.
	`BDU_ASSERT_IMPLY(a_backpressure, $past(in_valid && in_ready) && out_valid && !out_ready, !in_ready)

endmodule

bind branch_distance_unit_top bdu_checker #(
	.DISTANCE_WIDTH(DISTANCE_WIDTH)
) u_bdu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.outcome        (outcome),
	.true_distance  (true_distance),
	.false_distance (false_distance)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the branch-distance unit: directed rows, then random beats.
module tb_top;

	localparam int unsigned OPW = bdu_pkg::OPERAND_WIDTH_DEF;
	localparam int unsigned DW  = bdu_pkg::DISTANCE_WIDTH_DEF;
	localparam int unsigned FUNC_WIDTH = bdu_pkg::FUNC_WIDTH;
	localparam int unsigned K_WIDTH    = bdu_pkg::K_WIDTH;

	// Unused function codes at both ends of the free range.
	localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED_LO = 4'd9;
	localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED_HI = 4'd15;

	localparam logic signed [OPW-1:0] OP_MAX = {1'b0, {(OPW-1){1'b1}}};
	localparam logic signed [OPW-1:0] OP_MIN = {1'b1, {(OPW-1){1'b0}}};
	localparam logic [DW-1:0] DIST_MAX = '1;
	// Full operand span plus an offset of one.
	localparam logic [DW-1:0] FULL_SPAN_K1 = DW'(64'h1_0000_0000);

	localparam int RANDOM_PER_PHASE = 150;
	localparam int NUM_PHASES       = 4;

	typedef struct {
		logic [FUNC_WIDTH-1:0] func;
		logic signed [OPW-1:0] left;
		logic signed [OPW-1:0] right;
		logic                  lhs_o;
		logic [DW-1:0]         lhs_t;
		logic [DW-1:0]         lhs_f;
		logic                  rhs_o;
		logic [DW-1:0]         rhs_t;
		logic [DW-1:0]         rhs_f;
	} bd_op_t;

	typedef struct packed {
		logic          outcome;
		logic [DW-1:0] true_d;
		logic [DW-1:0] false_d;
	} bd_result_t;

	typedef struct {
		bd_op_t     op;
		bit         known;
		bd_result_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [K_WIDTH-1:0]    k_offset = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_WIDTH-1:0] func = '0;
	logic signed [OPW-1:0] left_operand = '0;
	logic signed [OPW-1:0] right_operand = '0;
	logic                  lhs_outcome = 1'b0;
	logic [DW-1:0]         lhs_true_dist = '0;
	logic [DW-1:0]         lhs_false_dist = '0;
	logic                  rhs_outcome = 1'b0;
	logic [DW-1:0]         rhs_true_dist = '0;
	logic [DW-1:0]         rhs_false_dist = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  outcome;
	logic [DW-1:0]         true_distance;
	logic [DW-1:0]         false_distance;

	// Typed-in answer that travels with a directed beat.
	logic       row_known = 1'b0;
	bd_result_t row_res = '0;

	bit quiet = 1'b0;
	logic [K_WIDTH-1:0] k_model = bdu_pkg::K_RESET;
	bd_result_t pending_results[$];
	dir_row_t directed_rows[$];
	int err_cnt = 0;
	int n_checked = 0;
	int n_directed = 0;
	int n_random = 0;
	int n_settings = 0;

	branch_distance_unit_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.k_offset       (k_offset),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.left_operand   (left_operand),
		.right_operand  (right_operand),
		.lhs_outcome    (lhs_outcome),
		.lhs_true_dist  (lhs_true_dist),
		.lhs_false_dist (lhs_false_dist),
		.rhs_outcome    (rhs_outcome),
		.rhs_true_dist  (rhs_true_dist),
		.rhs_false_dist (rhs_false_dist),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outcome        (outcome),
		.true_distance  (true_distance),
		.false_distance (false_distance)
	);

	always #5 clk = ~clk;

	// Sum of two distances, clamped at the all-ones value.
	function automatic logic [DW-1:0] sat_sum(input logic [DW-1:0] x, input logic [DW-1:0] y);
		logic [DW:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[DW] ? DIST_MAX : s[DW-1:0];
	endfunction

	// Outcome and both distances that the unit should give for one beat.
	function automatic bd_result_t eval_branch(input bd_op_t op, input logic [K_WIDTH-1:0] k);
		logic signed [OPW:0] diff;
		logic [OPW:0] gap;
		logic [DW-1:0] off_dist;
		bd_result_t r;
		r = '0;
		diff = {op.left[OPW-1], op.left} - {op.right[OPW-1], op.right};
		gap = diff[OPW] ? -diff : diff;
		off_dist = sat_sum(DW'(gap), DW'(k));
		case (op.func)
			bdu_pkg::FUNC_GT: r.outcome = op.left > op.right;
			bdu_pkg::FUNC_GE: r.outcome = op.left >= op.right;
			bdu_pkg::FUNC_LT: r.outcome = op.left < op.right;
			bdu_pkg::FUNC_LE: r.outcome = op.left <= op.right;
			bdu_pkg::FUNC_EQ: r.outcome = op.left == op.right;
			bdu_pkg::FUNC_NE: r.outcome = op.left != op.right;
			bdu_pkg::FUNC_AND: begin
				if (op.lhs_o && op.rhs_o) begin
					r.outcome = 1'b1;
					r.false_d = (op.lhs_f < op.rhs_f) ? op.lhs_f : op.rhs_f;
				end else begin
					r.true_d = sat_sum(op.lhs_t, op.rhs_t);
				end
			end
			bdu_pkg::FUNC_OR: begin
				if (op.lhs_o || op.rhs_o) begin
					r.outcome = 1'b1;
					r.false_d = sat_sum(op.lhs_f, op.rhs_f);
				end else begin
					r.true_d = (op.lhs_t < op.rhs_t) ? op.lhs_t : op.rhs_t;
				end
			end
			bdu_pkg::FUNC_NOT: begin
				r.outcome = !op.lhs_o;
				r.true_d = op.lhs_f;
				r.false_d = op.lhs_t;
			end
			default: r = '0;
		endcase
		// A comparison is off on exactly one side, always by |a - b| + k.
		if (op.func <= bdu_pkg::FUNC_NE) begin
			r.true_d = r.outcome ? '0 : off_dist;
			r.false_d = r.outcome ? off_dist : '0;
		end
		return r;
	endfunction

	function automatic logic signed [OPW-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return OP_MAX;
			1: return OP_MIN;
			2: return OPW'($urandom_range(0, 16)) - OPW'(8);
			default: return OPW'($urandom());
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_dist();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 4))
			0: return '0;
			1: return DW'($urandom_range(0, 1000));
			2: return DIST_MAX - DW'($urandom_range(0, 1000));
			default: return w[DW-1:0];
		endcase
	endfunction

	// Random beat: mostly valid codes, operands often equal or close.
	function automatic bd_op_t rand_op();
		bd_op_t op;
		if ($urandom_range(0, 99) < 6)
			op.func = FUNC_WIDTH'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
		else
			op.func = FUNC_WIDTH'($urandom_range(bdu_pkg::FUNC_GT, bdu_pkg::FUNC_NOT));
		op.left = rand_operand();
		case ($urandom_range(0, 3))
			0: op.right = op.left;
			1: op.right = op.left - OPW'(32) + OPW'($urandom_range(0, 64));
			default: op.right = rand_operand();
		endcase
		op.lhs_o = 1'($urandom_range(0, 1));
		op.rhs_o = 1'($urandom_range(0, 1));
		op.lhs_t = rand_dist();
		op.lhs_f = rand_dist();
		op.rhs_t = rand_dist();
		op.rhs_f = rand_dist();
		return op;
	endfunction

	// Comparison row; the sub-result fields carry random junk.
	task automatic add_cmp(input logic [FUNC_WIDTH-1:0] f, input logic signed [OPW-1:0] a,
			input logic signed [OPW-1:0] b, input bit known, input logic eo,
			input logic [DW-1:0] et, input logic [DW-1:0] ef);
		dir_row_t row;
		row.op = rand_op();
		row.op.func = f;
		row.op.left = a;
		row.op.right = b;
		row.known = known;
		row.res = {eo, et, ef};
		directed_rows.push_back(row);
	endtask

	// Combine row; the compared operands carry random junk.
	task automatic add_comb(input logic [FUNC_WIDTH-1:0] f, input logic lo,
			input logic [DW-1:0] lt, input logic [DW-1:0] lf, input logic ro,
			input logic [DW-1:0] rt, input logic [DW-1:0] rf, input bit known,
			input logic eo, input logic [DW-1:0] et, input logic [DW-1:0] ef);
		dir_row_t row;
		row.op = rand_op();
		row.op.func = f;
		row.op.lhs_o = lo;
		row.op.lhs_t = lt;
		row.op.lhs_f = lf;
		row.op.rhs_o = ro;
		row.op.rhs_t = rt;
		row.op.rhs_f = rf;
		row.known = known;
		row.res = {eo, et, ef};
		directed_rows.push_back(row);
	endtask

	// Present one beat, with random idle cycles ahead of it, and hold it until taken.
	task automatic send_beat(input bd_op_t op, input bit known, input bd_result_t res);
		while (!quiet && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op.func;
		left_operand <= op.left;
		right_operand <= op.right;
		lhs_outcome <= op.lhs_o;
		lhs_true_dist <= op.lhs_t;
		lhs_false_dist <= op.lhs_f;
		rhs_outcome <= op.rhs_o;
		rhs_true_dist <= op.rhs_t;
		rhs_false_dist <= op.rhs_f;
		row_known <= known;
		row_res <= res;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Offset writes happen only once every pending result is back.
	task automatic write_k_offset(input logic [K_WIDTH-1:0] v);
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		k_offset <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Output stalls follow the same idle rate as the input side.
	always @(posedge clk) begin
		out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 38);
	end

	// Track the offset, predict each accepted input beat and check each output beat.
	always @(posedge clk) begin : mon
		bd_op_t op;
		bd_result_t got;
		bd_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				k_model = k_offset;
			if (out_valid && out_ready) begin
				got = {outcome, true_distance, false_distance};
				if (pending_results.size() == 0) begin
					$error("result beat with no input pending");
					err_cnt++;
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (got.outcome !== want.outcome) begin
						$error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
						err_cnt++;
					end
					if (got.true_d !== want.true_d) begin
						$error("true_distance: expected %0h, got %0h", want.true_d, got.true_d);
						err_cnt++;
					end
					if (got.false_d !== want.false_d) begin
						$error("false_distance: expected %0h, got %0h",
							want.false_d, got.false_d);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				op.func = func;
				op.left = left_operand;
				op.right = right_operand;
				op.lhs_o = lhs_outcome;
				op.lhs_t = lhs_true_dist;
				op.lhs_f = lhs_false_dist;
				op.rhs_o = rhs_outcome;
				op.rhs_t = rhs_true_dist;
				op.rhs_f = rhs_false_dist;
				pending_results.push_back(row_known ? row_res : eval_branch(op, k_model));
			end
		end
	end

	initial begin : stim
		logic [K_WIDTH-1:0] k_plan [NUM_PHASES];
		k_plan[0] = '0;
		k_plan[1] = '1;
		k_plan[2] = K_WIDTH'($urandom_range(2, 254));
		k_plan[3] = bdu_pkg::K_RESET;

		// Directed rows at the reset offset of one.
		add_cmp(bdu_pkg::FUNC_GT, OP_MAX, OP_MIN, 1, 1'b1, '0, FULL_SPAN_K1);
		add_cmp(bdu_pkg::FUNC_GT, OP_MIN, OP_MAX, 1, 1'b0, FULL_SPAN_K1, '0);
		add_cmp(bdu_pkg::FUNC_GT, -3, 4, 0, 1'b0, '0, '0);
		add_cmp(bdu_pkg::FUNC_GE, 5, 5, 1, 1'b1, '0, DW'(1));
		add_cmp(bdu_pkg::FUNC_GE, OP_MIN, OP_MAX, 1, 1'b0, FULL_SPAN_K1, '0);
		add_cmp(bdu_pkg::FUNC_LT, OP_MIN, OP_MAX, 1, 1'b1, '0, FULL_SPAN_K1);
		add_cmp(bdu_pkg::FUNC_LT, -1, -1, 1, 1'b0, DW'(1), '0);
		add_cmp(bdu_pkg::FUNC_LE, 0, 0, 1, 1'b1, '0, DW'(1));
		add_cmp(bdu_pkg::FUNC_LE, OP_MAX, OP_MIN, 1, 1'b0, FULL_SPAN_K1, '0);
		add_cmp(bdu_pkg::FUNC_LE, 1000, -1000, 0, 1'b0, '0, '0);
		add_cmp(bdu_pkg::FUNC_EQ, OP_MIN, OP_MIN, 1, 1'b1, '0, DW'(1));
		add_cmp(bdu_pkg::FUNC_EQ, OP_MAX, OP_MIN, 1, 1'b0, FULL_SPAN_K1, '0);
		add_cmp(bdu_pkg::FUNC_EQ, 100, -100, 0, 1'b0, '0, '0);
		add_cmp(bdu_pkg::FUNC_NE, OP_MAX, OP_MAX, 1, 1'b0, DW'(1), '0);
		add_cmp(bdu_pkg::FUNC_NE, OP_MIN, OP_MAX, 1, 1'b1, '0, FULL_SPAN_K1);
		add_comb(bdu_pkg::FUNC_AND, 1'b1, DW'(3), DIST_MAX, 1'b1, DW'(8), DW'(5), 1, 1'b1,
			'0, DW'(5));
		// Saturating sums and minimums of the true and false distances, then the NOT swap.
		add_comb(bdu_pkg::FUNC_AND, 1'b0, DIST_MAX, '0, 1'b1, DIST_MAX, '0, 1, 1'b0,
			DIST_MAX, '0);
		add_comb(bdu_pkg::FUNC_AND, 1'b0, DW'(9), '0, 1'b0, DW'(7), '0, 0, 1'b0, '0, '0);
		add_comb(bdu_pkg::FUNC_OR, 1'b0, DW'(7), '0, 1'b0, DIST_MAX, '0, 1, 1'b0, DW'(7), '0);
		add_comb(bdu_pkg::FUNC_OR, 1'b1, '0, DIST_MAX, 1'b0, '0, DW'(1), 1, 1'b1, '0,
			DIST_MAX);
		add_comb(bdu_pkg::FUNC_OR, 1'b1, '0, DIST_MAX - DW'(1), 1'b1, '0, DW'(1), 1, 1'b1,
			'0, DIST_MAX);
		add_comb(bdu_pkg::FUNC_NOT, 1'b1, '0, DIST_MAX, 1'b1, DIST_MAX, '0, 1, 1'b0,
			DIST_MAX, '0);
		add_comb(bdu_pkg::FUNC_NOT, 1'b0, DIST_MAX, '0, 1'b0, '0, DIST_MAX, 1, 1'b1,
			'0, DIST_MAX);
		// Unused function codes give an all-zero result.
		add_cmp(FUNC_UNUSED_LO, OP_MAX, OP_MIN, 1, 1'b0, '0, '0);
		add_comb(FUNC_UNUSED_HI, 1'b1, DIST_MAX, DIST_MAX, 1'b1, DIST_MAX, DIST_MAX, 1, 1'b0,
			'0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].op, directed_rows[i].known, directed_rows[i].res);
			n_directed++;
		end
		in_valid <= 1'b0;

		// Random phases, one per offset setting; the third runs with no idling.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_k_offset(k_plan[p]);
			quiet = (p == 2);
			repeat (RANDOM_PER_PHASE) begin
				send_beat(rand_op(), 1'b0, '0);
				n_random++;
			end
			in_valid <= 1'b0;
			quiet = 1'b0;
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d directed and %0d random beats over %0d offset writes",
			n_directed, n_random, n_settings);
		$display("(0 and 255 included); compared %0d result beats, %0d field mismatches.",
			n_checked, err_cnt);
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: branch_distance_unit_top.f
+incdir+src
src/bdu_pkg.sv
src/branch_distance_unit_top.sv
src/bdu_checker.sv
sim/tb_top.sv
